// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg
// Constants, verdict codes and types shared by the frame checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

	localparam logic [7:0] START_BYTE  = 8'hDD;
	localparam logic [7:0] END_BYTE    = 8'h77;
	localparam logic [7:0] STATUS_BYTE = 8'h00;

	localparam int unsigned POS_W = 3;
	localparam logic [POS_W-1:0] POS_MAX = 3'd7;
	localparam logic [POS_W-1:0] POS_SUM = 3'd6; // history tail enters the sum from here

	localparam logic [2:0] VERDICT_OK        = 3'd0;
	localparam logic [2:0] VERDICT_SHORT     = 3'd1;
	localparam logic [2:0] VERDICT_BAD_START = 3'd2;
	localparam logic [2:0] VERDICT_BAD_END   = 3'd3;
	localparam logic [2:0] VERDICT_BAD_STAT  = 3'd4;
	localparam logic [2:0] VERDICT_BAD_SUM   = 3'd5;

	typedef struct packed {
		logic [2:0] verdict;
		logic       frame_ok;
		logic [7:0] command_byte;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/rfc_frame_eval.sv =====
// ----------------------------------------------------------------------------
// rfc_frame_eval
// Per-frame state and verdict logic for the byte held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_frame_eval (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [7:0]       byte_s1,
	input  wire logic             end_s1,
	output rfc_pkg::result_t      res
);

	logic [7:0]  hist_q [3];
	logic [rfc_pkg::POS_W-1:0] pos_q;
	logic [15:0] sum_q;
	logic        start_q;
	logic        status_q;
	logic [7:0]  cmd_q;

	logic [15:0] sum_nx;
	logic [15:0] crc;
	logic [7:0]  cmd_eff;
	logic        status_eff;

	always_comb begin
		sum_nx = sum_q;
		if (pos_q >= rfc_pkg::POS_SUM) begin
			sum_nx = sum_q + {8'h00, hist_q[2]};
		end
		crc        = 16'h0000 - sum_nx;
		cmd_eff    = (pos_q == 3'd1) ? byte_s1 : cmd_q;
		status_eff = (pos_q == 3'd2) ? (byte_s1 == rfc_pkg::STATUS_BYTE) : status_q;

		if (pos_q < 3'd2) begin
			res.verdict = rfc_pkg::VERDICT_SHORT;
		end else if (!start_q) begin
			res.verdict = rfc_pkg::VERDICT_BAD_START;
		end else if (byte_s1 != rfc_pkg::END_BYTE) begin
			res.verdict = rfc_pkg::VERDICT_BAD_END;
		end else if (!status_eff) begin
			res.verdict = rfc_pkg::VERDICT_BAD_STAT;
		end else if (hist_q[1] != crc[15:8] || hist_q[0] != crc[7:0]) begin
			res.verdict = rfc_pkg::VERDICT_BAD_SUM;
		end else begin
			res.verdict = rfc_pkg::VERDICT_OK;
		end
		res.frame_ok     = (res.verdict == rfc_pkg::VERDICT_OK);
		res.command_byte = (pos_q != 3'd0) ? cmd_eff : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0] <= 8'h00;
			hist_q[1] <= 8'h00;
			hist_q[2] <= 8'h00;
			pos_q     <= '0;
			sum_q     <= 16'h0000;
			start_q   <= 1'b0;
			status_q  <= 1'b0;
			cmd_q     <= 8'h00;
		end else if (advance) begin
			if (end_s1) begin
				// frame done: back to a clean slate
				hist_q[0] <= 8'h00;
				hist_q[1] <= 8'h00;
				hist_q[2] <= 8'h00;
				pos_q     <= '0;
				sum_q     <= 16'h0000;
				start_q   <= 1'b0;
				status_q  <= 1'b0;
				cmd_q     <= 8'h00;
			end else begin
				if (pos_q == 3'd0) begin
					start_q <= (byte_s1 == rfc_pkg::START_BYTE);
				end
				if (pos_q == 3'd1) begin
					cmd_q <= byte_s1;
				end
				if (pos_q == 3'd2) begin
					status_q <= (byte_s1 == rfc_pkg::STATUS_BYTE);
				end
				sum_q     <= sum_nx;
				hist_q[2] <= hist_q[1];
				hist_q[1] <= hist_q[0];
				hist_q[0] <= byte_s1;
				if (pos_q != rfc_pkg::POS_MAX) begin
					pos_q <= pos_q + 3'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/rfc_result_reg.sv =====
// ----------------------------------------------------------------------------
// rfc_result_reg
// Output register holding one verdict item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_result_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire rfc_pkg::result_t res,
	input  wire logic             out_ready,
	output logic                  busy,
	output logic                  out_valid,
	output logic [2:0]            verdict,
	output logic                  frame_ok,
	output logic [7:0]            command_byte
);

	logic             valid_q;
	rfc_pkg::result_t res_q;

	// slot stays occupied only if it holds an item that is not taken now
	assign busy = valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign verdict      = res_q.verdict;
	assign frame_ok     = res_q.frame_ok;
	assign command_byte = res_q.command_byte;

endmodule

`default_nettype wire

// ===== sv/response_frame_checker.sv =====
// ----------------------------------------------------------------------------
// response_frame_checker
// Byte-serial check of a response frame: framing, status and sum checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one frame byte per item in
//   rx_byte, with frame_end high on the final byte of the frame.
//   Output channel (out_valid/out_ready) carries one item per frame: verdict
//   (first failed check), frame_ok and the command byte at position 1.
//   Bytes that are not the final byte produce no output item.
//   The final byte is taken into the input register, then into the result
//   register once the result slot is free, where the verdict item is valid.
//   Throughput: one byte per cycle, except while a final byte waits for the
//   result slot; the checks are a single pass of narrow logic between the
//   input register and the per-frame state.
//   A stalled receiver holds the verdict in the result register; bytes keep
//   flowing until a second final byte reaches the input register, which then
//   waits for the result slot to free.
//   Reset (arst_n low) empties both registers and clears the frame state, so
//   the next accepted byte is taken as byte 0 of a new frame.
// ----------------------------------------------------------------------------
`default_nettype none

module response_frame_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_end,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      verdict,
	output logic            frame_ok,
	output logic [7:0]      command_byte
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	logic             advance;
	logic             busy;
	rfc_pkg::result_t res;

	// a plain byte always moves on; a final byte needs a free result slot
	assign advance  = valid_s1 && (!end_s1 || !busy);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
			end_s1  <= frame_end;
		end
	end

	// frame state and verdict for the byte in the input register
	rfc_frame_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.end_s1  (end_s1),
		.res     (res)
	);

	// result register; loads only on the final byte
	rfc_result_reg u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && end_s1),
		.res          (res),
		.out_ready    (out_ready),
		.busy         (busy),
		.out_valid    (out_valid),
		.verdict      (verdict),
		.frame_ok     (frame_ok),
		.command_byte (command_byte)
	);

endmodule

`default_nettype wire

// ===== sv/rfc_checker.sv =====
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level assertions for the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rfc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] verdict,
	input wire logic       frame_ok
);

	// a stalled item holds its verdict
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(verdict) && $stable(frame_ok))

	// frame_ok agrees with the verdict code
	`ASSERT_IMPLY(a_ok_match, clk, arst_n, out_valid, frame_ok == (verdict == rfc_pkg::VERDICT_OK))

	// only defined verdict codes leave the block
	`ASSERT_IMPLY(a_code_range, clk, arst_n, out_valid, verdict <= rfc_pkg::VERDICT_BAD_SUM)

endmodule

bind response_frame_checker rfc_checker u_rfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.verdict   (verdict),
	.frame_ok  (frame_ok)
);

`default_nettype wire
